// ===== design/zlhp_pkg.sv =====
`default_nettype none

package zlhp_pkg;

    // Parser phases; the numeric value of a field phase is also its record kind.
    typedef enum logic [4:0] {
        PH_SIG,
        PH_VERSION,
        PH_FLAGS,
        PH_METHOD,
        PH_TIME,
        PH_DATE,
        PH_CRC,
        PH_CSIZE,
        PH_USIZE,
        PH_NAMELEN,
        PH_EXTRALEN,
        PH_NAME,
        PH_EXTRA,
        PH_DATA,
        PH_DESC_CRC,
        PH_DESC_CSIZE,
        PH_DESC_USIZE,
        PH_SKIP
    } t_phase;

    typedef logic [4:0] t_kind;

    localparam t_kind KIND_SIG     = 5'd0;
    localparam t_kind KIND_UNKNOWN = 5'd17;
    localparam t_kind KIND_SKIP    = 5'd18;

    localparam logic [31:0] SIG_LOCAL       = 32'h04034b50;
    localparam logic [15:0] FLAG_DESCRIPTOR = 16'h0008;
    localparam logic [7:0]  CHAR_P          = 8'h50;
    localparam logic [7:0]  CHAR_K          = 8'h4B;
    localparam logic [31:0] SKIP_MAX        = 32'hFFFF_FFFF;
    localparam logic [15:0] ENTRY_MAX       = 16'hFFFF;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] shift;
        logic [31:0] left;
        logic [15:0] flags;
        logic [15:0] name_len;
        logic [15:0] extra_len;
        logic [31:0] comp_size;
        logic [15:0] entries;
        logic [47:0] pos;
        logic [31:0] skip;
        logic        seen_p;
        logic [47:0] fstart;
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] value;
        logic [15:0] entry;
        logic [47:0] offset;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:     PH_SIG,
        shift:     32'd0,
        left:      32'd4,
        flags:     16'd0,
        name_len:  16'd0,
        extra_len: 16'd0,
        comp_size: 32'd0,
        entries:   16'd0,
        pos:       48'd0,
        skip:      32'd0,
        seen_p:    1'b0,
        fstart:    48'd0
    };

    // Byte width of a fixed header field; zero for byte-stream phases.
    function automatic logic [2:0] field_width(t_phase p);
        logic [2:0] w;
        unique case (p)
            PH_SIG, PH_CRC, PH_CSIZE, PH_USIZE,
            PH_DESC_CRC, PH_DESC_CSIZE, PH_DESC_USIZE: w = 3'd4;
            PH_VERSION, PH_FLAGS, PH_METHOD, PH_TIME,
            PH_DATE, PH_NAMELEN, PH_EXTRALEN:          w = 3'd2;
            default:                                   w = 3'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/zlhp_step.sv =====
`default_nettype none

// Next-state and result logic for one archive byte.
module zlhp_step (
    input  zlhp_pkg::t_state  i_state,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_stream,
    input  logic              i_full_dump,
    output zlhp_pkg::t_state  o_state,
    output logic              o_res_valid,
    output zlhp_pkg::t_result o_res
);
    import zlhp_pkg::*;

    t_state      s;
    t_phase      p;
    t_result     res;
    logic        hit;
    logic [2:0]  w;
    logic [31:0] v;
    logic [31:0] total;

    function automatic logic [31:0] sat_inc(logic [31:0] c);
        return (c != SKIP_MAX) ? c + 32'd1 : c;
    endfunction

    function automatic t_state start_field(t_state st, t_phase np);
        t_state r;
        r       = st;
        r.phase = np;
        r.left  = {29'd0, field_width(np)};
        r.shift = 32'd0;
        return r;
    endfunction

    // Jump to the first non-empty body part at or after np.
    function automatic t_state go_body(t_state st, t_phase np);
        t_state r;
        r = st;
        if (np <= PH_NAME && st.name_len != 16'd0) begin
            r.phase = PH_NAME;
            r.left  = {16'd0, st.name_len};
        end else if (np <= PH_EXTRA && st.extra_len != 16'd0) begin
            r.phase = PH_EXTRA;
            r.left  = {16'd0, st.extra_len};
        end else if (np <= PH_DATA && st.comp_size != 32'd0) begin
            r.phase = PH_DATA;
            r.left  = st.comp_size;
        end else if (np <= PH_DESC_CRC && (st.flags & FLAG_DESCRIPTOR) != 16'd0) begin
            r = start_field(st, PH_DESC_CRC);
        end else begin
            r.phase  = PH_SKIP;
            r.left   = 32'd0;
            r.skip   = 32'd0;
            r.seen_p = 1'b0;
        end
        return r;
    endfunction

    always_comb begin
        s     = i_state;
        p     = i_state.phase;
        hit   = 1'b0;
        res   = '0;
        w     = 3'd0;
        v     = 32'd0;
        total = 32'd0;

        if (p <= PH_EXTRALEN || (p >= PH_DESC_CRC && p <= PH_DESC_USIZE)) begin
            // fixed-width little-endian field
            w = field_width(p);
            if (s.left == {29'd0, w}) begin
                s.fstart = s.pos;
            end
            s.shift = {i_data_byte, s.shift[31:8]};
            if (s.left != 32'd0) begin
                s.left = s.left - 32'd1;
            end
            if (s.left == 32'd0) begin
                v = (w == 3'd4) ? s.shift : {16'd0, s.shift[31:16]};
                if (p == PH_SIG) begin
                    if (v == SIG_LOCAL) begin
                        if (s.entries != ENTRY_MAX) begin
                            s.entries = s.entries + 16'd1;
                        end
                        hit = 1'b1;
                        res = '{KIND_SIG, v, s.entries, s.fstart};
                        s   = start_field(s, PH_VERSION);
                    end else begin
                        hit = 1'b1;
                        res = '{KIND_UNKNOWN, v, s.entries, s.fstart};
                        s   = go_body(s, PH_SKIP);
                    end
                end else begin
                    if (p == PH_FLAGS)    s.flags     = v[15:0];
                    if (p == PH_CSIZE)    s.comp_size = v;
                    if (p == PH_NAMELEN)  s.name_len  = v[15:0];
                    if (p == PH_EXTRALEN) s.extra_len = v[15:0];
                    hit = 1'b1;
                    res = '{t_kind'(p), v, s.entries, s.fstart};
                    if (p < PH_EXTRALEN || (p >= PH_DESC_CRC && p < PH_DESC_USIZE)) begin
                        s = start_field(s, t_phase'(p + 5'd1));
                    end else if (p == PH_EXTRALEN) begin
                        s = go_body(s, PH_NAME);
                    end else begin
                        s = go_body(s, PH_SKIP);
                    end
                end
            end
        end else if (p >= PH_NAME && p <= PH_DATA) begin
            // name, extra and data bytes
            if (p != PH_DATA || i_full_dump) begin
                hit = 1'b1;
                res = '{t_kind'(p), {24'd0, i_data_byte}, s.entries, s.pos};
            end
            if (s.left != 32'd0) begin
                s.left = s.left - 32'd1;
            end
            if (s.left == 32'd0) begin
                s = go_body(s, t_phase'(p + 5'd1));
            end
        end else begin
            // resync: hunt for "PK"
            if (s.seen_p && i_data_byte == CHAR_K) begin
                s.seen_p = 1'b0;
                if (s.skip != 32'd0) begin
                    hit = 1'b1;
                    res = '{KIND_SKIP, s.skip, s.entries, s.pos - 48'd1};
                end
                s.skip   = 32'd0;
                s.phase  = PH_SIG;
                s.shift  = {CHAR_K, CHAR_P, 16'd0};
                s.left   = 32'd2;
                s.fstart = s.pos - 48'd1;
            end else begin
                if (s.seen_p) begin
                    s.skip = sat_inc(s.skip);
                end
                s.seen_p = (i_data_byte == CHAR_P);
                if (!s.seen_p) begin
                    s.skip = sat_inc(s.skip);
                end
            end
        end

        s.pos = s.pos + 48'd1;

        if (i_end_of_stream) begin
            if (s.phase == PH_SKIP && !hit) begin
                total = s.skip;
                if (s.seen_p) begin
                    total = sat_inc(total);
                end
                if (total != 32'd0) begin
                    hit = 1'b1;
                    res = '{KIND_SKIP, total, s.entries, s.pos};
                end
            end
            s = STATE_RESET;
        end
    end

    assign o_state     = s;
    assign o_res_valid = hit;
    assign o_res       = res;

endmodule

`default_nettype wire

// ===== design/zip_local_header_parser.sv =====
`default_nettype none

// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+-------------------------------------
// input     | in        | i_in_valid / o_in_stall    | i_data_byte, i_end_of_stream
// result    | out       | o_out_valid / i_out_stall  | o_record_kind, o_field_value,
//           |           |                            | o_entry_number, o_field_offset
// config    | in        | i_cfg_valid / o_cfg_ready  | i_cfg_full_dump
//
// Throughput is one byte per cycle unless a held result stalls the parse stage; the limit
// is the parser state loop in zlhp_step. Each byte is held in the input register, its result in the result register.
// Each byte yields zero or one result item.
// i_rst_n is synchronous, active low: parser state returns to the first signature,
// full dump mode clears to 0.
// A held result (i_out_stall) freezes the parse stage; an empty input register still
// takes one more byte, then o_in_stall rises.
module zip_local_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_stream,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [4:0]  o_record_kind,
    output logic [31:0] o_field_value,
    output logic [15:0] o_entry_number,
    output logic [47:0] o_field_offset,
    // config write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_full_dump
);
    import zlhp_pkg::*;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_eos;

    // parser state and mode
    t_state      r_state;
    t_state      n_state;
    logic        r_full_dump;

    // result register
    logic        r_out_valid;
    t_result     r_out;

    logic        step_hit;
    t_result     step_res;
    logic        advance;
    logic        in_take;

    // The parse stage moves only when the result slot is free or draining.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;

    zlhp_step u_step (
        .i_state         (r_state),
        .i_data_byte     (r_byte),
        .i_end_of_stream (r_eos),
        .i_full_dump     (r_full_dump),
        .o_state         (n_state),
        .o_res_valid     (step_hit),
        .o_res           (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_byte <= i_data_byte;
            r_eos  <= i_end_of_stream;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_dump <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_full_dump <= i_cfg_full_dump;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step_hit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_hit) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_record_kind  = r_out.kind;
    assign o_field_value  = r_out.value;
    assign o_entry_number = r_out.entry;
    assign o_field_offset = r_out.offset;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
module tb;
    import zlhp_pkg::*;

    localparam int QUIET_LIMIT = 2000;   // cycles with no handshake at all
    localparam int HOLD_CYCLES = 250;    // long receiver hold-off
    localparam logic [31:0] SIG_CENTRAL = 32'h02014b50;
    localparam logic [31:0] SIG_END     = 32'h06054b50;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} t_stall_style;
    typedef enum int {ARC_RECORDS, ARC_UNKNOWN, ARC_CUT, ARC_WILD} t_arc_shape;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_end_of_stream;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [4:0]  o_record_kind;
    logic [31:0] o_field_value;
    logic [15:0] o_entry_number;
    logic [47:0] o_field_offset;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_full_dump;

    zip_local_header_parser uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_record_kind   (o_record_kind),
        .o_field_value   (o_field_value),
        .o_entry_number  (o_entry_number),
        .o_field_offset  (o_field_offset),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_full_dump (i_cfg_full_dump)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Parser shadow: walks the same byte stream and queues the records
    // the block should report.
    // ------------------------------------------------------------------
    t_phase      walk_phase;
    logic [31:0] field_acc;
    logic [31:0] bytes_due;
    logic [15:0] hdr_flags;
    logic [15:0] name_len;
    logic [15:0] extra_len;
    logic [31:0] data_len;
    logic [15:0] entry_ctr;
    logic [47:0] byte_pos;
    logic [31:0] skipped;
    logic        p_held;
    logic [47:0] field_at;
    logic        dump_mode;

    t_result     awaited_records[$];
    logic [7:0]  archive_bytes[$];

    int error_count = 0;
    int items_sent  = 0;
    int burst_left  = 0;

    function automatic int field_bytes(t_phase ph);
        case (ph)
            PH_SIG, PH_CRC, PH_CSIZE, PH_USIZE,
            PH_DESC_CRC, PH_DESC_CSIZE, PH_DESC_USIZE: return 4;
            PH_NAME, PH_EXTRA, PH_DATA, PH_SKIP:       return 0;
            default:                                   return 2;
        endcase
    endfunction

    function automatic void open_field(t_phase ph);
        walk_phase = ph;
        bytes_due  = field_bytes(ph);
        field_acc  = '0;
    endfunction

    // First non-empty part of the record at or after ph; else hunt for "PK".
    function automatic void next_part(t_phase ph);
        if (ph <= PH_NAME && name_len != 0) begin
            walk_phase = PH_NAME;
            bytes_due  = {16'd0, name_len};
        end else if (ph <= PH_EXTRA && extra_len != 0) begin
            walk_phase = PH_EXTRA;
            bytes_due  = {16'd0, extra_len};
        end else if (ph <= PH_DATA && data_len != 0) begin
            walk_phase = PH_DATA;
            bytes_due  = data_len;
        end else if (ph <= PH_DESC_CRC && (hdr_flags & FLAG_DESCRIPTOR) != 0) begin
            open_field(PH_DESC_CRC);
        end else begin
            walk_phase = PH_SKIP;
            bytes_due  = '0;
            skipped    = '0;
            p_held     = 1'b0;
        end
    endfunction

    function automatic void restart_walk();
        open_field(PH_SIG);
        hdr_flags = '0;
        name_len  = '0;
        extra_len = '0;
        data_len  = '0;
        entry_ctr = '0;
        byte_pos  = '0;
        skipped   = '0;
        p_held    = 1'b0;
        field_at  = '0;
    endfunction

    function automatic void log_record(t_kind k, logic [31:0] v, logic [47:0] at);
        t_result r;
        r.kind   = k;
        r.value  = v;
        r.entry  = entry_ctr;
        r.offset = at;
        awaited_records.push_back(r);
    endfunction

    function automatic void bump_skip();
        if (skipped != SKIP_MAX) skipped++;
    endfunction

    function automatic void walk_byte(logic [7:0] b, logic last);
        logic [47:0] pos;
        t_phase      ph;
        int          w;
        int          queued;
        logic [31:0] v;
        logic [31:0] total;
        pos    = byte_pos;
        ph     = walk_phase;
        queued = awaited_records.size();
        if (ph <= PH_EXTRALEN || (ph >= PH_DESC_CRC && ph <= PH_DESC_USIZE)) begin
            // fixed-width little-endian field
            w = field_bytes(ph);
            if (bytes_due == w) field_at = pos;
            field_acc = {b, field_acc[31:8]};
            if (bytes_due != 0) bytes_due--;
            if (bytes_due == 0) begin
                v = field_acc >> (32 - 8 * w);
                if (ph == PH_SIG) begin
                    if (v == SIG_LOCAL) begin
                        if (entry_ctr != ENTRY_MAX) entry_ctr++;
                        log_record(KIND_SIG, v, field_at);
                        open_field(PH_VERSION);
                    end else begin
                        log_record(KIND_UNKNOWN, v, field_at);
                        next_part(PH_SKIP);
                    end
                end else begin
                    case (ph)
                        PH_FLAGS:    hdr_flags = v[15:0];
                        PH_CSIZE:    data_len  = v;
                        PH_NAMELEN:  name_len  = v[15:0];
                        PH_EXTRALEN: extra_len = v[15:0];
                        default: ;
                    endcase
                    log_record(t_kind'(ph), v, field_at);
                    if (ph == PH_EXTRALEN)       next_part(PH_NAME);
                    else if (ph == PH_DESC_USIZE) next_part(PH_SKIP);
                    else                          open_field(t_phase'(ph + 5'd1));
                end
            end
        end else if (ph >= PH_NAME && ph <= PH_DATA) begin
            if (ph != PH_DATA || dump_mode) log_record(t_kind'(ph), {24'd0, b}, pos);
            if (bytes_due != 0) bytes_due--;
            if (bytes_due == 0) next_part(t_phase'(ph + 5'd1));
        end else begin
            // between records: count bytes until a "PK" pair
            if (p_held && b == CHAR_K) begin
                p_held = 1'b0;
                if (skipped != 0) log_record(KIND_SKIP, skipped, pos - 48'd1);
                skipped    = '0;
                walk_phase = PH_SIG;
                field_acc  = {CHAR_K, CHAR_P, 16'd0};
                bytes_due  = 32'd2;
                field_at   = pos - 48'd1;
            end else begin
                if (p_held) bump_skip();
                p_held = (b == CHAR_P);
                if (!p_held) bump_skip();
            end
        end
        byte_pos = pos + 48'd1;
        if (last) begin
            // pending skip (with a dangling P) is flushed unless a record went out
            if (walk_phase == PH_SKIP && awaited_records.size() == queued) begin
                total = skipped;
                if (p_held && total != SKIP_MAX) total++;
                if (total != 0) log_record(KIND_SKIP, total, byte_pos);
            end
            restart_walk();
        end
    endfunction

    // ------------------------------------------------------------------
    // Archive builders
    // ------------------------------------------------------------------
    function automatic void add_word(logic [31:0] value, int n);
        for (int i = 0; i < n; i++) archive_bytes.push_back(value[8*i +: 8]);
    endfunction

    function automatic void add_bytes(int n);
        logic [7:0] r;
        for (int i = 0; i < n; i++) begin
            r = 8'($urandom);
            archive_bytes.push_back(r);
        end
    endfunction

    // stray bytes between records, rich in lone P's
    function automatic void add_junk(int n);
        logic [7:0] r;
        for (int i = 0; i < n; i++) begin
            r = 8'($urandom);
            archive_bytes.push_back(($urandom_range(0, 3) == 0) ? CHAR_P : r);
        end
    endfunction

    function automatic void add_header(logic [15:0] flags, logic [31:0] csize,
                                       logic [15:0] nlen, logic [15:0] xlen);
        add_word(SIG_LOCAL, 4);
        add_word($urandom, 2);   // version
        add_word({16'd0, flags}, 2);
        add_word($urandom, 2);   // method
        add_word($urandom, 2);   // time
        add_word($urandom, 2);   // date
        add_word($urandom, 4);   // crc
        add_word(csize, 4);
        add_word($urandom, 4);   // uncompressed size
        add_word({16'd0, nlen}, 2);
        add_word({16'd0, xlen}, 2);
    endfunction

    function automatic int pick_len();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 2)  return 0;
        if (roll < 16) return $urandom_range(1, 4);
        return $urandom_range(5, 24);
    endfunction

    function automatic void add_record(int nlen, int xlen, int dlen, bit desc);
        logic [15:0] flags;
        flags = 16'($urandom);
        flags = (flags & ~FLAG_DESCRIPTOR) | (desc ? FLAG_DESCRIPTOR : 16'd0);
        add_header(flags, 32'(dlen), 16'(nlen), 16'(xlen));
        add_bytes(nlen + xlen + dlen);
        if (desc) add_bytes(12);
    endfunction

    // Mostly clean record chains with random content; the rest is noise,
    // unknown signatures and archives cut short.
    function automatic void build_random_archive();
        int         roll;
        int         cut;
        t_arc_shape shape;
        roll  = $urandom_range(0, 9);
        shape = (roll < 7) ? ARC_RECORDS : t_arc_shape'(roll - 6);
        case (shape)
            ARC_RECORDS: begin
                repeat ($urandom_range(1, 4)) begin
                    add_record(pick_len(), pick_len(), pick_len(),
                               1'($urandom_range(0, 1)));
                    add_junk($urandom_range(0, 5));
                end
            end
            ARC_UNKNOWN: begin
                case ($urandom_range(0, 2))
                    0:       add_word(SIG_CENTRAL, 4);
                    1:       add_word(SIG_END, 4);
                    default: add_word($urandom, 4);
                endcase
                add_junk($urandom_range(0, 12));
                if ($urandom_range(0, 1) == 1)
                    add_record(pick_len(), pick_len(), pick_len(),
                               1'($urandom_range(0, 1)));
            end
            ARC_CUT: begin
                add_record(pick_len(), pick_len(), pick_len(), 1'($urandom_range(0, 1)));
                cut = $urandom_range(1, archive_bytes.size());
                while (archive_bytes.size() > cut) void'(archive_bytes.pop_back());
            end
            default: begin
                // header with fully random fields, followed by up to 30 random bytes
                add_word(SIG_LOCAL, 4);
                add_bytes(26 + $urandom_range(0, 30));
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of items with random gaps between them
    // ------------------------------------------------------------------
    task automatic offer_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid      <= 1'b1;
        i_data_byte     <= b;
        i_end_of_stream <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        walk_byte(b, last);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_archive();
        while (archive_bytes.size() != 0) begin
            offer_byte(archive_bytes[0], archive_bytes.size() == 1);
            void'(archive_bytes.pop_front());
        end
    endtask

    // Called at a falling edge; returns at a falling edge with nothing pending.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (awaited_records.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);   // items with no record may still be in flight
        @(negedge i_clk);
    endtask

    task automatic set_dump_mode(input logic on);
        drain_results();
        i_cfg_valid     <= 1'b1;
        i_cfg_full_dump <= on;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        dump_mode = on;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: the stall style is re-picked whenever its random stretch runs out; a
    // requested hold-off is counted here.
    // ------------------------------------------------------------------
    int           hold_asked   = 0;
    int           holds_served = 0;
    int           hold_left    = 0;
    int           style_left   = 0;
    t_stall_style stall_style  = STALL_NONE;
    logic [15:0]  stall_mask   = '0;

    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (holds_served != hold_asked) begin
            holds_served = hold_asked;
            hold_left    = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            if (style_left == 0) begin
                stall_style = t_stall_style'($urandom_range(0, 2));
                style_left  = $urandom_range(40, 300);
                stall_mask  = 16'($urandom);
            end
            style_left--;
            stall_mask = {stall_mask[0], stall_mask[15:1]};
            case (stall_style)
                STALL_NONE:   i_out_stall <= 1'b0;
                STALL_RANDOM: i_out_stall <= ($urandom_range(0, 2) == 0);
                default:      i_out_stall <= stall_mask[0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Record checker
    // ------------------------------------------------------------------
    t_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_records.size() == 0) begin
                error_count++;
                $display("%0t: unexpected record: kind %0d value %h entry %0d offset %h",
                         $time, o_record_kind, o_field_value, o_entry_number,
                         o_field_offset);
            end else begin
                want = awaited_records.pop_front();
                if (o_record_kind !== want.kind || o_field_value !== want.value ||
                    o_entry_number !== want.entry || o_field_offset !== want.offset) begin
                    error_count++;
                    $display("%0t: record mismatch: expected kind %0d value %h entry %0d offset %h",
                             $time, want.kind, want.value, want.entry, want.offset);
                    $display("%0t: record mismatch: actual kind %0d value %h entry %0d offset %h",
                             $time, o_record_kind, o_field_value, o_entry_number,
                             o_field_offset);
                end
            end
        end
    end

    // Watchdog: no handshake on any channel for too long
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_cases();
        set_dump_mode(1'b1);
        // record with name, data and descriptor; then stray bytes with lone P's,
        // a central directory signature, and a trailing P at end of stream
        add_header(FLAG_DESCRIPTOR, 32'd2, 16'd1, 16'd0);
        archive_bytes = {archive_bytes, 8'hFF, 8'h00, 8'hFF};
        add_bytes(12);
        archive_bytes = {archive_bytes, CHAR_P, 8'h11, CHAR_P, CHAR_P, CHAR_K,
                         8'h01, 8'h02, 8'h33, CHAR_P};
        send_archive();
        // all parts empty, no descriptor; stream ends on the K of a resync
        add_header(16'h0000, 32'd0, 16'd0, 16'd0);
        archive_bytes = {archive_bytes, CHAR_P, CHAR_K};
        send_archive();
        // truncated signature
        archive_bytes = {archive_bytes, CHAR_P, CHAR_K, 8'h03};
        send_archive();
        // widest sizes, cut off inside the extra field
        add_header(16'hFFFF, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF);
        archive_bytes = {archive_bytes, 8'h00, 8'hFF};
        send_archive();
    endtask

    task automatic test_random_archives(input int upto, input logic on);
        set_dump_mode(on);
        while (items_sent < upto) begin
            build_random_archive();
            send_archive();
        end
    endtask

    // Receiver holds off for a long stretch while records keep coming in,
    // so the block backs up and stalls its input.
    task automatic test_backpressure();
        drain_results();
        @(posedge i_clk);
        hold_asked++;
        @(negedge i_clk);
        repeat (3) add_record($urandom_range(1, 6), $urandom_range(1, 6),
                              $urandom_range(1, 6), 1'($urandom_range(0, 1)));
        send_archive();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_data_byte     = '0;
        i_end_of_stream = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_full_dump = 1'b0;
        dump_mode       = 1'b0;
        restart_walk();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_archives(700, 1'b0);
        test_backpressure();
        test_random_archives(1200, 1'b1);
        test_random_archives(1450, 1'b0);

        drain_results();
        if (error_count == 0 && awaited_records.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
